/* hw/rtl/ruvq_pkg.sv */
package ruvq_pkg;

    // Array geometry
    localparam int ARRAY_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int POS_W       = 11;
    localparam int VAL_W       = 10;
    localparam int RIGHT_W     = 11;

    // Position code meaning "no such element"
    localparam logic [POS_W-1:0] NONE_CODE = POS_W'(ARRAY_DEPTH);

    // Command codes carried in s_tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_READ,
        ST_LD_WRITE,
        ST_LD_LINK,
        ST_Q_SCAN,
        ST_Q_DONE
    } state_t;

    // Request as seen by the engine
    typedef struct packed {
        logic               cmd;
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   left;
        logic [RIGHT_W-1:0] right;
    } req_t;

    // Query result
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
    } res_t;

endpackage

/* hw/rtl/ruvq_engine.sv */
module ruvq_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  ruvq_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output ruvq_pkg::res_t res
);

    localparam int IDX_W   = ruvq_pkg::IDX_W;
    localparam int POS_W   = ruvq_pkg::POS_W;
    localparam int VAL_W   = ruvq_pkg::VAL_W;
    localparam int DEPTH   = ruvq_pkg::ARRAY_DEPTH;

    ruvq_pkg::state_t state_reg, state_next;
    ruvq_pkg::req_t   req_reg, req_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [POS_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             found_reg, found_next;
    logic [VAL_W-1:0] uval_reg, uval_next;
    logic [POS_W-1:0] link_prior_reg, link_prior_next;
    logic [POS_W-1:0] link_pos_reg, link_pos_next;

    // Storage
    logic [VAL_W-1:0] val_mem  [DEPTH];
    logic [POS_W-1:0] prev_mem [DEPTH];
    logic [POS_W-1:0] next_mem [DEPTH];
    logic [POS_W-1:0] lp_mem   [DEPTH];
    logic [VAL_W-1:0] val_q;
    logic [POS_W-1:0] prev_q, next_q, lp_q;

    logic             ld_we;
    logic             next_we;
    logic [IDX_W-1:0] next_waddr;
    logic [POS_W-1:0] next_wdata;
    logic             lp_we;
    logic [IDX_W-1:0] lp_waddr;
    logic [POS_W-1:0] lp_wdata;
    logic [IDX_W-1:0] scan_addr;
    logic [POS_W-1:0] left_ext;
    logic             before_ok, after_ok;

    assign scan_addr = rd_idx_reg[IDX_W-1:0];
    assign left_ext  = {1'b0, req_reg.left};

    // Element value and previous link, written at the append position
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            val_mem[cnt_reg[IDX_W-1:0]]  <= req_reg.value;
            prev_mem[cnt_reg[IDX_W-1:0]] <= lp_q;
        end
        val_q  <= val_mem[scan_addr];
        prev_q <= prev_mem[scan_addr];
    end

    // Next link: set to none on append, patched on the older copy after
    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_q <= next_mem[scan_addr];
    end

    // Last position per value: cleared after reset, updated per append
    always_ff @(posedge aclk) begin
        if (lp_we) begin
            lp_mem[lp_waddr] <= lp_wdata;
        end
        lp_q <= lp_mem[req_reg.value];
    end

    // Scan test on the entry read last cycle
    assign before_ok = (prev_q == ruvq_pkg::NONE_CODE) || (prev_q < left_ext);
    assign after_ok  = (next_q == ruvq_pkg::NONE_CODE) || (next_q >= req_reg.right);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ruvq_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        uval_reg       <= uval_next;
        link_prior_reg <= link_prior_next;
        link_pos_reg   <= link_pos_next;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        clr_idx_next    = clr_idx_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = 1'b0;
        found_next      = found_reg;
        uval_next       = uval_reg;
        link_prior_next = link_prior_reg;
        link_pos_next   = link_pos_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        ld_we           = 1'b0;
        next_we         = 1'b0;
        next_waddr      = cnt_reg[IDX_W-1:0];
        next_wdata      = ruvq_pkg::NONE_CODE;
        lp_we           = 1'b0;
        lp_waddr        = req_reg.value;
        lp_wdata        = cnt_reg;

        case (state_reg)
            ruvq_pkg::ST_CLEAR: begin
                lp_we        = 1'b1;
                lp_waddr     = clr_idx_reg;
                lp_wdata     = ruvq_pkg::NONE_CODE;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(DEPTH - 1)) begin
                    state_next = ruvq_pkg::ST_IDLE;
                end
            end

            ruvq_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next    = req;
                    rd_idx_next = {1'b0, req.left};
                    found_next  = 1'b0;
                    uval_next   = '0;
                    if (req.cmd == ruvq_pkg::CMD_LOAD) begin
                        // full array: drop the load
                        if (cnt_reg != POS_W'(DEPTH)) begin
                            state_next = ruvq_pkg::ST_LD_READ;
                        end
                    end else if (({1'b0, req.left} >= req.right) || (req.right > cnt_reg)) begin
                        state_next = ruvq_pkg::ST_Q_DONE;
                    end else begin
                        state_next = ruvq_pkg::ST_Q_SCAN;
                    end
                end
            end

            // last-position read in flight
            ruvq_pkg::ST_LD_READ: begin
                state_next = ruvq_pkg::ST_LD_WRITE;
            end

            ruvq_pkg::ST_LD_WRITE: begin
                ld_we           = 1'b1;
                next_we         = 1'b1;
                lp_we           = 1'b1;
                link_prior_next = lp_q;
                link_pos_next   = cnt_reg;
                cnt_next        = cnt_reg + 1'b1;
                if (lp_q != ruvq_pkg::NONE_CODE) begin
                    state_next = ruvq_pkg::ST_LD_LINK;
                end else begin
                    state_next = ruvq_pkg::ST_IDLE;
                end
            end

            ruvq_pkg::ST_LD_LINK: begin
                next_we    = 1'b1;
                next_waddr = link_prior_reg[IDX_W-1:0];
                next_wdata = link_pos_reg;
                state_next = ruvq_pkg::ST_IDLE;
            end

            // one read issued and one entry tested per cycle
            ruvq_pkg::ST_Q_SCAN: begin
                if (rd_vld_reg && before_ok && after_ok) begin
                    found_next = 1'b1;
                    uval_next  = val_q;
                    state_next = ruvq_pkg::ST_Q_DONE;
                end else if (rd_idx_reg < req_reg.right) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end else if (!rd_vld_reg) begin
                    state_next = ruvq_pkg::ST_Q_DONE;
                end
            end

            ruvq_pkg::ST_Q_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ruvq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ruvq_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.found = found_reg;
    assign res.value = uval_reg;

endmodule

/* hw/rtl/range_unique_value_query_top.sv */
// Range single-occurrence query.
// Input channel (s_*): s_tuser selects the request kind. A load appends
// element_value to the array (up to 1024 entries; loads beyond that are
// dropped) and gives no result. A query names the range
// [left_index, right_end) and gives one result on the m_* channel: found in
// m_tuser and, when found, the value at the lowest index that occurs only
// once in the range (zero otherwise).
// A load reads the last-position table, then writes the element and its
// links, and patches the older copy's next link when the value was seen
// before. A query scans from left_index upward and stops at the first hit;
// an empty range, or one past the loaded entries, skips the scan. The scan
// of the link memories goes one entry per cycle on their single read port.
// One request is worked on at a time; s_tready is low meanwhile.
// After aresetn the block sweeps all 1024 entries of its last-position table
// with s_tready low. A result sits in the output register until taken; the
// block takes the next request meanwhile, and only a second finished query
// waits for m_tready.
module range_unique_value_query_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // element_value[9:0], left_index[19:10], right_end[30:20]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // unique_value[9:0]
    output logic        m_tuser    // found
);

    localparam int VAL_W = ruvq_pkg::VAL_W;

    ruvq_pkg::req_t req;
    ruvq_pkg::res_t res;
    logic           res_valid;
    logic           res_ready;

    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [VAL_W-1:0] m_value_reg, m_value_next;

    // Unpack the request
    assign req.cmd   = s_tuser;
    assign req.value = s_tdata[9:0];
    assign req.left  = s_tdata[19:10];
    assign req.right = s_tdata[30:20];

    ruvq_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_value_next = m_value_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_found_next = res.found;
            m_value_next = res.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_value_reg <= m_value_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {(16 - VAL_W)'(0), m_value_reg};

endmodule
